@@ rtl/als_pkg.sv @@
`timescale 1ns / 1ps

package als_pkg;

  // Chain geometry
  localparam int LED_COUNT    = 16;
  localparam int LED_AW       = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int BITS_PER_LED = 24;
  localparam int BIT_W        = 5;
  localparam int COLOR_W      = 24;
  localparam int BLINK_STEP   = 10;

  // Item field widths
  localparam int CMD_W   = 3;
  localparam int INDEX_W = 16;
  localparam int WORD_W  = 32;

  // Configuration port
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;
  localparam int TICK_W = 8;
  localparam int LATCH_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_SET_ONE = 3'd1,
    CMD_SET_ALL = 3'd2,
    CMD_BLINK   = 3'd3,
    CMD_REFRESH = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IW-1:0] {
    REG_ONE_HIGH  = 3'd0,
    REG_ONE_LOW   = 3'd1,
    REG_ZERO_HIGH = 3'd2,
    REG_ZERO_LOW  = 3'd3,
    REG_LATCH     = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_LATCH = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    WALK_NONE  = 2'd0,
    WALK_SET   = 2'd1,
    WALK_BLINK = 2'd2
  } walk_e;

  typedef enum logic {
    ST_ACCEPT = 1'b0,
    ST_EXEC   = 1'b1
  } seq_e;

  typedef struct packed {
    logic [TICK_W-1:0]  one_high;
    logic [TICK_W-1:0]  one_low;
    logic [TICK_W-1:0]  zero_high;
    logic [TICK_W-1:0]  zero_low;
    logic [LATCH_W-1:0] latch;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic [LED_AW-1:0]  waddr;
    logic [COLOR_W-1:0] wdata;
    logic               re;
    logic [LED_AW-1:0]  raddr;
  } mem_req_t;

endpackage

@@ rtl/als_if.sv @@
`timescale 1ns / 1ps

// Command channel
interface als_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [als_pkg::CMD_W-1:0]    cmd;
  logic [als_pkg::INDEX_W-1:0]  led_index;
  logic [als_pkg::WORD_W-1:0]   color;

  modport source (output valid, output cmd, output led_index, output color, input ready);
  modport sink   (input valid, input cmd, input led_index, input color, output ready);
endinterface

// Result channel
interface als_res_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic rejected;

  modport source (output valid, output line_level, output busy_res, output rejected,
                  input ready);
  modport sink   (input valid, input line_level, input busy_res, input rejected,
                  output ready);
endinterface

@@ rtl/als_cfg.sv @@
`timescale 1ns / 1ps

module als_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [als_pkg::CFG_IW-1:0]  cfg_index_i,
  input  logic [als_pkg::CFG_DW-1:0]  cfg_wdata_i,
  output als_pkg::cfg_t               cfg_o
);

  als_pkg::cfg_t cfg_q, cfg_d;

  // Register decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        als_pkg::REG_ONE_HIGH:  cfg_d.one_high  = cfg_wdata_i[als_pkg::TICK_W-1:0];
        als_pkg::REG_ONE_LOW:   cfg_d.one_low   = cfg_wdata_i[als_pkg::TICK_W-1:0];
        als_pkg::REG_ZERO_HIGH: cfg_d.zero_high = cfg_wdata_i[als_pkg::TICK_W-1:0];
        als_pkg::REG_ZERO_LOW:  cfg_d.zero_low  = cfg_wdata_i[als_pkg::TICK_W-1:0];
        als_pkg::REG_LATCH:     cfg_d.latch     = cfg_wdata_i[als_pkg::LATCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_high  <= 8'd12;
      cfg_q.one_low   <= 8'd3;
      cfg_q.zero_high <= 8'd5;
      cfg_q.zero_low  <= 8'd10;
      cfg_q.latch     <= 16'd100;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/als_store.sv @@
`timescale 1ns / 1ps

// Color store: one write and one read port, registered read data.
// Per-entry valid bits make unwritten entries read as zero after reset.
module als_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  als_pkg::mem_req_t             req_i,
  output logic [als_pkg::COLOR_W-1:0]   rdata_o
);

  logic [als_pkg::COLOR_W-1:0]   mem_q [als_pkg::LED_COUNT];
  logic [als_pkg::LED_COUNT-1:0] valid_q;
  logic [als_pkg::COLOR_W-1:0]   rdata_q;
  logic                          rvalid_q;

  // Storage array
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  // Written flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvalid_q <= valid_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

@@ rtl/als_ctrl.sv @@
`timescale 1ns / 1ps

// Accept/execute sequencer: the accept cycle decodes the command and reads the
// store, the execute cycle advances the walk or the line timing, writes
// back and loads the result register.
module als_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  als_cmd_if.sink                     cmd_if,
  als_res_if.source                   res_if,
  input  als_pkg::cfg_t               cfg_i,
  output als_pkg::mem_req_t           mem_req_o,
  input  logic [als_pkg::COLOR_W-1:0] mem_rdata_i
);

  localparam logic [als_pkg::LED_AW-1:0]  LastLed = als_pkg::LED_AW'(als_pkg::LED_COUNT - 1);
  localparam logic [als_pkg::BIT_W-1:0]   LastBit = als_pkg::BIT_W'(als_pkg::BITS_PER_LED - 1);
  localparam logic [als_pkg::INDEX_W-1:0] IdxLimit = als_pkg::INDEX_W'(als_pkg::LED_COUNT);
  localparam logic [als_pkg::COLOR_W-1:0] BlinkAdd = als_pkg::COLOR_W'(als_pkg::BLINK_STEP);

  als_pkg::seq_e  st_q, st_d;
  als_pkg::walk_e walk_q, walk_d;
  als_pkg::phase_e phase_q, phase_d;
  logic [als_pkg::LED_AW-1:0]   wptr_q, wptr_d;
  logic [als_pkg::COLOR_W-1:0]  wcolor_q, wcolor_d;
  logic [als_pkg::LED_AW-1:0]   led_q, led_d;
  logic [als_pkg::BIT_W-1:0]    bit_q, bit_d;
  logic [als_pkg::LATCH_W-1:0]  cnt_q, cnt_d;
  logic                         rej_q, rej_d;

  logic out_valid_q, out_valid_d;
  logic line_q, line_d;
  logic busy_q, busy_d;
  logic rejo_q, rejo_d;

  logic accept, step_en, in_ready;
  logic busy_now, cur_bit;
  logic [als_pkg::LATCH_W-1:0] len;
  logic [als_pkg::LATCH_W:0]   cnt_inc;

  // Sequencer next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      als_pkg::ST_ACCEPT: if (accept) st_d = als_pkg::ST_EXEC;
      als_pkg::ST_EXEC:   st_d = als_pkg::ST_ACCEPT;
      default:            st_d = als_pkg::ST_ACCEPT;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    step_en  = 1'b0;
    case (st_q)
      als_pkg::ST_ACCEPT: in_ready = !out_valid_q || res_if.ready;
      als_pkg::ST_EXEC:   step_en  = 1'b1;
      default: ;
    endcase
  end

  assign accept       = cmd_if.valid && in_ready;
  assign cmd_if.ready = in_ready;
  assign busy_now     = (walk_q != als_pkg::WALK_NONE) || (phase_q != als_pkg::PH_IDLE);

  // Phase length from the bit read out of the store
  assign cur_bit = mem_rdata_i[bit_q];
  always_comb begin
    case (phase_q)
      als_pkg::PH_HIGH: len = {8'h00, cur_bit ? cfg_i.one_high : cfg_i.zero_high};
      als_pkg::PH_LOW:  len = {8'h00, cur_bit ? cfg_i.one_low : cfg_i.zero_low};
      default:          len = cfg_i.latch;
    endcase
  end
  assign cnt_inc = {1'b0, cnt_q} + 17'd1;

  // Command decode and per-item step
  always_comb begin
    walk_d    = walk_q;
    phase_d   = phase_q;
    wptr_d    = wptr_q;
    wcolor_d  = wcolor_q;
    led_d     = led_q;
    bit_d     = bit_q;
    cnt_d     = cnt_q;
    rej_d     = rej_q;
    line_d    = line_q;
    busy_d    = busy_q;
    rejo_d    = rejo_q;
    mem_req_o = '0;
    out_valid_d = (out_valid_q && !res_if.ready) ? 1'b1 : 1'b0;

    if (accept) begin
      rej_d = 1'b0;
      if (cmd_if.cmd != als_pkg::CMD_TICK && busy_now) begin
        rej_d = 1'b1;
      end else begin
        case (cmd_if.cmd)
          als_pkg::CMD_TICK: ;
          als_pkg::CMD_SET_ONE: begin
            if (cmd_if.color[als_pkg::WORD_W-1:als_pkg::COLOR_W] != '0 ||
                cmd_if.led_index >= IdxLimit) begin
              rej_d = 1'b1;
            end else begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = cmd_if.led_index[als_pkg::LED_AW-1:0];
              mem_req_o.wdata = cmd_if.color[als_pkg::COLOR_W-1:0];
            end
          end
          als_pkg::CMD_SET_ALL: begin
            if (cmd_if.color[als_pkg::WORD_W-1:als_pkg::COLOR_W] != '0) begin
              rej_d = 1'b1;
            end else begin
              walk_d   = als_pkg::WALK_SET;
              wptr_d   = '0;
              wcolor_d = cmd_if.color[als_pkg::COLOR_W-1:0];
            end
          end
          als_pkg::CMD_BLINK: begin
            walk_d = als_pkg::WALK_BLINK;
            wptr_d = '0;
          end
          als_pkg::CMD_REFRESH: begin
            phase_d = als_pkg::PH_HIGH;
            led_d   = '0;
            bit_d   = '0;
            cnt_d   = '0;
          end
          default: rej_d = 1'b1;
        endcase
      end
      // Fetch the entry the execute cycle works on
      mem_req_o.re    = 1'b1;
      mem_req_o.raddr = (walk_d == als_pkg::WALK_BLINK) ? wptr_d : led_d;
    end else if (step_en) begin
      busy_d = 1'b0;
      line_d = 1'b0;
      // Store walk, one entry per item
      if (walk_q != als_pkg::WALK_NONE) begin
        busy_d          = 1'b1;
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = wptr_q;
        mem_req_o.wdata = (walk_q == als_pkg::WALK_SET) ? wcolor_q : mem_rdata_i + BlinkAdd;
        if (wptr_q == LastLed) begin
          wptr_d = '0;
          walk_d = als_pkg::WALK_NONE;
        end else begin
          wptr_d = wptr_q + 1'b1;
        end
      end
      // Line timing
      if (phase_q != als_pkg::PH_IDLE) begin
        busy_d = 1'b1;
        line_d = (phase_q == als_pkg::PH_HIGH);
        cnt_d  = cnt_inc[als_pkg::LATCH_W-1:0];
        if (cnt_inc >= {1'b0, len}) begin
          cnt_d = '0;
          case (phase_q)
            als_pkg::PH_HIGH: phase_d = als_pkg::PH_LOW;
            als_pkg::PH_LOW: begin
              if (bit_q == LastBit) begin
                bit_d = '0;
                if (led_q == LastLed) begin
                  led_d   = '0;
                  phase_d = als_pkg::PH_LATCH;
                end else begin
                  led_d   = led_q + 1'b1;
                  phase_d = als_pkg::PH_HIGH;
                end
              end else begin
                bit_d   = bit_q + 1'b1;
                phase_d = als_pkg::PH_HIGH;
              end
            end
            default: phase_d = als_pkg::PH_IDLE;
          endcase
        end
      end
      rejo_d      = rej_q;
      out_valid_d = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= als_pkg::ST_ACCEPT;
      walk_q      <= als_pkg::WALK_NONE;
      phase_q     <= als_pkg::PH_IDLE;
      wptr_q      <= '0;
      led_q       <= '0;
      bit_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      walk_q      <= walk_d;
      phase_q     <= phase_d;
      wptr_q      <= wptr_d;
      led_q       <= led_d;
      bit_q       <= bit_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    wcolor_q <= wcolor_d;
    rej_q    <= rej_d;
    line_q   <= line_d;
    busy_q   <= busy_d;
    rejo_q   <= rejo_d;
  end

  assign res_if.valid      = out_valid_q;
  assign res_if.line_level = line_q;
  assign res_if.busy_res   = busy_q;
  assign res_if.rejected   = rejo_q;

endmodule

@@ rtl/addressable_led_serializer.sv @@
`timescale 1ns / 1ps

// Addressable LED chain serializer.
// Command channel (cmd_if): each item is one line tick carrying a command:
//   tick, set one LED, set all LEDs, blink (add 10 to every color), refresh.
// Result channel (res_if): exactly one item per command item, in order,
//   giving the line level for that tick, the busy flag and a reject flag.
// Config port: cfg_we_i/cfg_index_i/cfg_wdata_i write the bit and latch
//   timing registers; write only while no item is in flight.
// Item flow: an item is not taken before the last one is through. The store
//   is a single-port-read synchronous RAM; each item needs a read step and a
//   modify/write-back step, and the next read waits for that write.
// Result timing: an accepted item passes the execute state and then the
//   output register, where its result goes valid.
// Stalls: a finished result sits in an output register; the next item is
//   taken while the receiver takes it, and held off while it is not taken.
// Reset: timing registers return to defaults and all colors read as zero
//   (per-entry written flags, so no clearing pass is needed).
module addressable_led_serializer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  als_cmd_if.sink                    cmd_if,
  als_res_if.source                  res_if,
  input  logic                       cfg_we_i,
  input  logic [als_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [als_pkg::CFG_DW-1:0] cfg_wdata_i
);

  als_pkg::cfg_t               cfg;
  als_pkg::mem_req_t           mem_req;
  logic [als_pkg::COLOR_W-1:0] mem_rdata;

  als_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  als_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  als_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_if      (cmd_if),
    .res_if      (res_if),
    .cfg_i       (cfg),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

endmodule

@@ rtl/als_checker.sv @@
`timescale 1ns / 1ps

module als_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic cmd_valid_i,
  input logic cmd_ready_i,
  input logic res_valid_i,
  input logic res_ready_i,
  input logic line_level_i,
  input logic busy_res_i,
  input logic rejected_i
);

  // Held result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i &&
      $stable(line_level_i) && $stable(busy_res_i) && $stable(rejected_i))
    else $error("stalled result changed");

  // Sequencer takes no item during its execute cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("item taken during execute cycle");

  // Every item yields a result after the execute state and output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |-> ##2 res_valid_i)
    else $error("result missing after item");

  // Line high only while a frame runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && line_level_i |-> busy_res_i)
    else $error("line high while not busy");

endmodule

bind addressable_led_serializer als_checker u_als_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cmd_valid_i  (cmd_if.valid),
  .cmd_ready_i  (cmd_if.ready),
  .res_valid_i  (res_if.valid),
  .res_ready_i  (res_if.ready),
  .line_level_i (res_if.line_level),
  .busy_res_i   (res_if.busy_res),
  .rejected_i   (res_if.rejected)
);

@@ tb/sv/addressable_led_serializer_tb.sv @@
`timescale 1ns / 1ps

module addressable_led_serializer_tb;

  typedef logic [als_pkg::CMD_W-1:0]   cmd_word_t;
  typedef logic [als_pkg::INDEX_W-1:0] idx_t;
  typedef logic [als_pkg::WORD_W-1:0]  word_t;
  typedef logic [als_pkg::CFG_DW-1:0]  cfg_word_t;
  typedef logic [als_pkg::COLOR_W-1:0] color_t;

  localparam int        NUM_LEDS         = als_pkg::LED_COUNT;
  localparam int        FRAME_BITS       = als_pkg::LED_COUNT * als_pkg::BITS_PER_LED;
  localparam word_t     COLOR_MAX        = word_t'((1 << als_pkg::COLOR_W) - 1);
  localparam cmd_word_t CMD_FIRST_UNUSED = cmd_word_t'(als_pkg::CMD_REFRESH + 1);
  localparam color_t    BLINK_ADD        = color_t'(als_pkg::BLINK_STEP);
  localparam int        STALL_LIMIT      = 2000;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic rejected;
  } line_res_t;

  logic clk_i;
  logic rst_ni;
  logic                         cfg_we_i;
  logic [als_pkg::CFG_IW-1:0]   cfg_index_i;
  cfg_word_t                    cfg_wdata_i;

  als_cmd_if cmd_if ();
  als_res_if res_if ();

  addressable_led_serializer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_if      (cmd_if),
    .res_if      (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Predictor state: timing registers, color store, line and walk sequencers
  logic [als_pkg::TICK_W-1:0]  t_one_high;
  logic [als_pkg::TICK_W-1:0]  t_one_low;
  logic [als_pkg::TICK_W-1:0]  t_zero_high;
  logic [als_pkg::TICK_W-1:0]  t_zero_low;
  logic [als_pkg::LATCH_W-1:0] t_latch;
  color_t                      pixel_colors [NUM_LEDS];
  int unsigned                 bit_pos;
  int unsigned                 ph_cnt;
  als_pkg::phase_e             line_ph;
  int unsigned                 walk_ptr;
  als_pkg::walk_e              walk_st;
  color_t                      walk_color;

  line_res_t line_results_q [$];
  int unsigned errors;
  int unsigned stall_cnt;
  bit gaps_on;

  // Clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic word_t rnd_word();
    return $urandom;
  endfunction

  function automatic idx_t rnd_index();
    return idx_t'($urandom);
  endfunction

  function automatic logic chain_busy();
    return (walk_st != als_pkg::WALK_NONE) || (line_ph != als_pkg::PH_IDLE);
  endfunction

  // Length of the line phase now running, from the bit being sent
  function automatic int unsigned phase_span();
    logic b;
    b = pixel_colors[bit_pos / als_pkg::BITS_PER_LED][bit_pos % als_pkg::BITS_PER_LED];
    if (line_ph == als_pkg::PH_HIGH) return 32'(b ? t_one_high : t_zero_high);
    if (line_ph == als_pkg::PH_LOW) return 32'(b ? t_one_low : t_zero_low);
    return 32'(t_latch);
  endfunction

  // One line tick: apply the command, advance walk and frame, queue the result
  task automatic predict_line_tick(input cmd_word_t c, input idx_t idx, input word_t col);
    line_res_t r;
    int unsigned span;
    r = '0;
    if (c != als_pkg::CMD_TICK) begin
      if (chain_busy() || c > als_pkg::CMD_REFRESH) begin
        r.rejected = 1'b1;
      end else begin
        case (c)
          als_pkg::CMD_SET_ONE: begin
            if (col > COLOR_MAX || idx >= NUM_LEDS) r.rejected = 1'b1;
            else pixel_colors[idx[als_pkg::LED_AW-1:0]] = col[als_pkg::COLOR_W-1:0];
          end
          als_pkg::CMD_SET_ALL: begin
            if (col > COLOR_MAX) begin
              r.rejected = 1'b1;
            end else begin
              walk_st    = als_pkg::WALK_SET;
              walk_ptr   = 0;
              walk_color = col[als_pkg::COLOR_W-1:0];
            end
          end
          als_pkg::CMD_BLINK: begin
            walk_st  = als_pkg::WALK_BLINK;
            walk_ptr = 0;
          end
          default: begin
            line_ph = als_pkg::PH_HIGH;
            bit_pos = 0;
            ph_cnt  = 0;
          end
        endcase
      end
    end
    // store walk, one entry per tick
    if (walk_st != als_pkg::WALK_NONE) begin
      r.busy_res = 1'b1;
      if (walk_st == als_pkg::WALK_SET) pixel_colors[walk_ptr] = walk_color;
      else pixel_colors[walk_ptr] = pixel_colors[walk_ptr] + BLINK_ADD;
      walk_ptr++;
      if (walk_ptr >= NUM_LEDS) begin
        walk_ptr = 0;
        walk_st  = als_pkg::WALK_NONE;
      end
    end
    // line sequencer
    if (line_ph != als_pkg::PH_IDLE) begin
      span         = phase_span();
      r.busy_res   = 1'b1;
      r.line_level = (line_ph == als_pkg::PH_HIGH);
      ph_cnt++;
      if (ph_cnt >= span) begin
        ph_cnt = 0;
        case (line_ph)
          als_pkg::PH_HIGH: line_ph = als_pkg::PH_LOW;
          als_pkg::PH_LOW: begin
            bit_pos++;
            if (bit_pos >= FRAME_BITS) begin
              bit_pos = 0;
              line_ph = als_pkg::PH_LATCH;
            end else begin
              line_ph = als_pkg::PH_HIGH;
            end
          end
          default: line_ph = als_pkg::PH_IDLE;
        endcase
      end
    end
    line_results_q.push_back(r);
  endtask

  // Send one command item; valid stays up until a gap or the caller idles the channel
  task automatic send_cmd(input cmd_word_t c, input idx_t idx, input word_t col);
    while (gaps_on && $urandom_range(99) < 15) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.cmd       <= c;
    cmd_if.led_index <= idx;
    cmd_if.color     <= col;
    do @(posedge clk_i); while (!cmd_if.ready);
    predict_line_tick(c, idx, col);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic settle();
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (line_results_q.size() != 0);
  endtask

  task automatic write_reg(input als_pkg::cfg_idx_e r, input cfg_word_t v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= r;
    cfg_wdata_i <= v;
    case (r)
      als_pkg::REG_ONE_HIGH:  t_one_high  = v[als_pkg::TICK_W-1:0];
      als_pkg::REG_ONE_LOW:   t_one_low   = v[als_pkg::TICK_W-1:0];
      als_pkg::REG_ZERO_HIGH: t_zero_high = v[als_pkg::TICK_W-1:0];
      als_pkg::REG_ZERO_LOW:  t_zero_low  = v[als_pkg::TICK_W-1:0];
      default:                t_latch     = v[als_pkg::LATCH_W-1:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_timing(input cfg_word_t oh, input cfg_word_t ol,
                            input cfg_word_t zh, input cfg_word_t zl,
                            input cfg_word_t lt);
    write_reg(als_pkg::REG_ONE_HIGH, oh);
    write_reg(als_pkg::REG_ONE_LOW, ol);
    write_reg(als_pkg::REG_ZERO_HIGH, zh);
    write_reg(als_pkg::REG_ZERO_LOW, zl);
    write_reg(als_pkg::REG_LATCH, lt);
  endtask

  // Mostly legal colors, with the boundary and wide values mixed in
  function automatic word_t pick_color();
    case ($urandom_range(9))
      0:       return COLOR_MAX;
      1:       return COLOR_MAX + 1;
      2:       return $urandom;
      default: return $urandom & COLOR_MAX;
    endcase
  endfunction

  function automatic idx_t pick_index();
    case ($urandom_range(9))
      0:       return idx_t'($urandom_range(16'hFFFF, NUM_LEDS));
      1:       return idx_t'(NUM_LEDS);
      default: return idx_t'($urandom_range(NUM_LEDS - 1));
    endcase
  endfunction

  // One tick, sometimes carrying a command that a busy chain turns away
  task automatic send_filler(input int unsigned cmd_pct);
    if ($urandom_range(99) < cmd_pct)
      send_cmd(cmd_word_t'($urandom_range(7, 1)), pick_index(), pick_color());
    else
      send_cmd(als_pkg::CMD_TICK, rnd_index(), rnd_word());
  endtask

  // Tick until walk and frame are done
  task automatic run_out(input int unsigned cmd_pct);
    while (chain_busy()) send_filler(cmd_pct);
  endtask

  // Tick until the frame reaches the given bit or its latch
  task automatic advance(input int unsigned stop_bit, input int unsigned cmd_pct);
    while ((line_ph == als_pkg::PH_HIGH || line_ph == als_pkg::PH_LOW) &&
           bit_pos < stop_bit)
      send_filler(cmd_pct);
  endtask

  task automatic test_idle_ticks();
    send_cmd(als_pkg::CMD_TICK, '0, '0);
    send_cmd(als_pkg::CMD_TICK, '1, '1);
    send_cmd(als_pkg::CMD_TICK, rnd_index(), rnd_word());
    settle();
  endtask

  task automatic test_set_one();
    send_cmd(als_pkg::CMD_SET_ONE, '0, COLOR_MAX);
    send_cmd(als_pkg::CMD_SET_ONE, idx_t'(NUM_LEDS - 1), '0);
    send_cmd(als_pkg::CMD_SET_ONE, idx_t'(NUM_LEDS), 32'h1);   // index equal to count
    send_cmd(als_pkg::CMD_SET_ONE, '1, 32'h1);
    send_cmd(als_pkg::CMD_SET_ONE, idx_t'(3), COLOR_MAX + 1);
    send_cmd(als_pkg::CMD_SET_ONE, idx_t'(3), '1);
    settle();
  endtask

  task automatic test_unknown_cmds();
    for (int c = CMD_FIRST_UNUSED; c <= 7; c++)
      send_cmd(cmd_word_t'(c), rnd_index(), rnd_word());
    settle();
  endtask

  task automatic test_walks();
    send_cmd(als_pkg::CMD_SET_ALL, rnd_index(), COLOR_MAX);
    // everything nonzero is turned away while the walk runs
    send_cmd(als_pkg::CMD_SET_ONE, '0, 32'h5);
    send_cmd(als_pkg::CMD_BLINK, '0, '0);
    send_cmd(als_pkg::CMD_REFRESH, '0, '0);
    send_cmd(als_pkg::CMD_SET_ALL, '0, '0);
    run_out(0);
    send_cmd(als_pkg::CMD_BLINK, rnd_index(), rnd_word());     // wraps every entry
    run_out(20);
    send_cmd(als_pkg::CMD_SET_ALL, '0, COLOR_MAX + 1);
    send_cmd(als_pkg::CMD_SET_ALL, '0, 32'h0012_3456);
    run_out(0);
    settle();
  endtask

  // Frame start at reset timing; LED 0 bits 4 and 5 are a one then a zero
  task automatic test_frame_default();
    for (int i = 0; i < NUM_LEDS; i++)
      send_cmd(als_pkg::CMD_SET_ONE, idx_t'(i), rnd_word() & COLOR_MAX);
    send_cmd(als_pkg::CMD_SET_ONE, '0, (rnd_word() & COLOR_MAX & ~32'h30) | 32'h10);
    send_cmd(als_pkg::CMD_REFRESH, rnd_index(), rnd_word());
    advance(4, 10);
    settle();
  endtask

  // Longest one-high and zero-low phases, switched in mid-frame
  task automatic test_timing_extremes();
    set_timing(16'd255, 16'd1, 16'd1, 16'd255, 16'd100);
    advance(6, 5);
    settle();
  endtask

  // Zero-length phases for the rest of the frame
  task automatic test_zero_timing();
    // upper data bits are dropped for the 8-bit registers
    set_timing(16'hFF00, 16'h0, 16'h0, 16'h0100, 16'hFFFF);
    advance(FRAME_BITS, 5);
    settle();
  endtask

  // Longest latch, cut short by a smaller latch register
  task automatic test_long_latch();
    gaps_on = 1'b0;
    repeat (30) send_filler(1);
    settle();
    write_reg(als_pkg::REG_LATCH, 16'h0);
    run_out(5);
    settle();
    gaps_on = 1'b1;
  endtask

  task automatic test_random();
    int unsigned pick;
    for (int p = 0; p < 4; p++) begin
      settle();
      gaps_on = (p != 2);
      set_timing(cfg_word_t'($urandom_range(3)), cfg_word_t'($urandom_range(3)),
                 cfg_word_t'($urandom_range(3)), cfg_word_t'($urandom_range(3)),
                 cfg_word_t'($urandom_range(40)));
      for (int n = 0; n < 105; n++) begin
        pick = $urandom_range(99);
        if (pick < 35)
          send_cmd(als_pkg::CMD_TICK, rnd_index(), rnd_word());
        else if (pick < 65)
          send_cmd(als_pkg::CMD_SET_ONE, pick_index(), pick_color());
        else if (pick < 75)
          send_cmd(als_pkg::CMD_SET_ALL, rnd_index(), pick_color());
        else if (pick < 89)
          send_cmd(als_pkg::CMD_BLINK, rnd_index(), rnd_word());
        else if (pick < 90)
          send_cmd(als_pkg::CMD_REFRESH, rnd_index(), rnd_word());
        else
          send_cmd(cmd_word_t'($urandom_range(7, CMD_FIRST_UNUSED)), rnd_index(),
                   rnd_word());
      end
    end
    settle();
    gaps_on = 1'b1;
  endtask

  // Result sink: compare each accepted item, then pick the next ready level
  always @(posedge clk_i) begin : res_check
    line_res_t want;
    if (res_if.valid && res_if.ready) begin
      if (line_results_q.size() == 0) begin
        $error("unexpected result item: line_level %0b busy_res %0b rejected %0b",
               res_if.line_level, res_if.busy_res, res_if.rejected);
        errors++;
      end else begin
        want = line_results_q.pop_front();
        if (res_if.line_level !== want.line_level) begin
          $error("line_level expected %0b got %0b", want.line_level, res_if.line_level);
          errors++;
        end
        if (res_if.busy_res !== want.busy_res) begin
          $error("busy_res expected %0b got %0b", want.busy_res, res_if.busy_res);
          errors++;
        end
        if (res_if.rejected !== want.rejected) begin
          $error("rejected expected %0b got %0b", want.rejected, res_if.rejected);
          errors++;
        end
      end
    end
    res_if.ready <= gaps_on ? ($urandom_range(99) >= 15) : 1'b1;
  end

  // Watchdog on cycles with no item moving on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
        stall_cnt <= 0;
      else
        stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("addressable_led_serializer_tb failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_index_i      <= als_pkg::REG_ONE_HIGH;
    cfg_wdata_i      <= '0;
    cmd_if.valid     <= 1'b0;
    cmd_if.cmd       <= als_pkg::CMD_TICK;
    cmd_if.led_index <= '0;
    cmd_if.color     <= '0;
    gaps_on     = 1'b1;
    t_one_high  = 8'd12;
    t_one_low   = 8'd3;
    t_zero_high = 8'd5;
    t_zero_low  = 8'd10;
    t_latch     = 16'd100;
    for (int i = 0; i < NUM_LEDS; i++) pixel_colors[i] = '0;
    bit_pos    = 0;
    ph_cnt     = 0;
    line_ph    = als_pkg::PH_IDLE;
    walk_ptr   = 0;
    walk_st    = als_pkg::WALK_NONE;
    walk_color = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_ticks();
    test_set_one();
    test_unknown_cmds();
    test_walks();
    test_frame_default();
    test_timing_extremes();
    test_zero_timing();
    test_long_latch();
    test_random();

    settle();
    repeat (8) @(posedge clk_i);
    if (errors == 0)
      $display("addressable_led_serializer_tb passed");
    else
      $display("addressable_led_serializer_tb failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/als_pkg.sv
rtl/als_if.sv
rtl/als_cfg.sv
rtl/als_store.sv
rtl/als_ctrl.sv
rtl/addressable_led_serializer.sv
rtl/als_checker.sv
tb/sv/addressable_led_serializer_tb.sv
